@@ hdl/mrnlms_pkg.sv @@
package mrnlms_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS = 32;
	localparam int STEP_BITS = 16;
	localparam int CFRAC = COEF_BITS - 8;
	localparam int NUM_SH = CFRAC - 12;
	// Magnitude of residual times regressor sample is at most 2^30.
	localparam int PROD_BITS = 2 * SAMPLE_BITS - 1;
	localparam int SCALED_BITS = PROD_BITS + STEP_BITS - 1;
	localparam int MAG_BITS = SCALED_BITS + NUM_SH;
	localparam int NORM_ONE_SH = 2 * (SAMPLE_BITS - 1);
	// The divisor is at least 2^30, so the quotient stays below 2^28.
	localparam int QUO_BITS = MAG_BITS - NORM_ONE_SH;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd18432;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_MAC,
		ST_MAC_DRAIN,
		ST_OUT,
		ST_NORM,
		ST_NORM_DRAIN,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_SCALE,
		ST_UPD_DIV,
		ST_UPD_WAIT,
		ST_UPD_WR
	} state_t;

	typedef struct packed {
		logic done;
		logic round_up;
		logic [QUO_BITS-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [63:0] sat_to(input logic signed [63:0] v, input int bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] r;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) r = hi;
		else if (v < lo) r = lo;
		else r = v;
		return r;
	endfunction

endpackage

@@ hdl/mrnlms_ram.sv @@
module mrnlms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/mrnlms_div.sv @@
module mrnlms_div #(
	parameter int DEN_W = 35
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mrnlms_pkg::MAG_BITS-1:0] num,
	input logic [DEN_W-1:0] den,
	output mrnlms_pkg::div_rsp_t rsp
);

	localparam int QB = mrnlms_pkg::QUO_BITS;
	localparam int CNT_W = $clog2(QB + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QB-1:0] low_q;
	logic [QB-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] trial;
	logic take;

	assign trial = {rem_q, low_q[QB-1]};
	assign take = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper part of the dividend is below the divisor, so only the
	// quotient bits that can be nonzero are developed, one per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[mrnlms_pkg::MAG_BITS-1:QB]);
			den_q <= den;
			low_q <= num[QB-1:0];
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= {low_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.round_up = {rem_q, 1'b0} >= {1'b0, den_q};
	assign rsp.quo = quo_q;

endmodule

@@ hdl/multi_reference_nlms_anc_filter_core.sv @@
// Channel     | Handshake                        | Payload
// ------------+----------------------------------+----------------------------------
// input       | in_valid / in_ready              | ref_0..ref_3, error_mic
// output      | out_valid / out_ready            | anti_noise, residual
// step config | step_size_wr_en (no wait)        | step_size
//
// The filtering of a sample is bound by the single MAC, which reads one tap and one
// coefficient from memory per cycle. Every second sample then adapts: a norm pass
// for each channel, then an update of each of its coefficients through the
// one-bit-per-cycle divider.
// After reset, the memories are cleared before the first sample is accepted.
// A waiting result sits in the output register; only the next result stalls.
module multi_reference_nlms_anc_filter_core #(
	parameter int TAPS = 15,
	parameter int CHANNELS = 4,
	parameter int DELAY_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	input logic step_size_wr_en,
	input logic [mrnlms_pkg::STEP_BITS-1:0] step_size,
	input logic in_valid,
	output logic in_ready,
	input logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] ref_0,
	input logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] ref_1,
	input logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] ref_2,
	input logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] ref_3,
	input logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] error_mic,
	output logic out_valid,
	input logic out_ready,
	output logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] anti_noise,
	output logic signed [mrnlms_pkg::SAMPLE_BITS-1:0] residual
);

	localparam int SB = mrnlms_pkg::SAMPLE_BITS;
	localparam int CB = mrnlms_pkg::COEF_BITS;
	localparam int TW = $clog2(TAPS);
	localparam int DW = $clog2(DELAY_DEPTH);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TC = TAPS * CHANNELS;
	localparam int DC = DELAY_DEPTH * CHANNELS;
	localparam int AT = $clog2(TC);
	localparam int AD = $clog2(DC);
	localparam int CLR_N = (TC > DC) ? TC : DC;
	localparam int CLW = (CLR_N > 1) ? $clog2(CLR_N) : 1;
	localparam int ACC_W = SB + CB + $clog2(TC);
	localparam int DEN_W = mrnlms_pkg::NORM_ONE_SH + 1 + $clog2(TAPS + 1);
	localparam int QB = mrnlms_pkg::QUO_BITS;

	localparam logic [TW-1:0] T_LAST = TW'(TAPS - 1);
	localparam logic [DW-1:0] D_LAST = DW'(DELAY_DEPTH - 1);
	localparam logic [CW-1:0] C_LAST = CW'(CHANNELS - 1);
	localparam logic [AT-1:0] T_STEP = AT'(TAPS);
	localparam logic [AD-1:0] D_STEP = AD'(DELAY_DEPTH);
	localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_N - 1);
	localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(64'd1 << mrnlms_pkg::NORM_ONE_SH);
	localparam logic signed [ACC_W:0] RND_HALF =
		(ACC_W+1)'(64'sd1 <<< (mrnlms_pkg::CFRAC - 1));

	mrnlms_pkg::state_t state_q, state_d;

	logic [TW-1:0] p_q, j_q, k_q;
	logic [DW-1:0] dp_q;
	logic [CW-1:0] ch_q;
	logic [AT-1:0] bt_q;
	logic [AD-1:0] bd_q;
	logic [CLW-1:0] clr_q;
	logic phase_q;
	logic [mrnlms_pkg::STEP_BITS-1:0] step_q;
	logic signed [SB-1:0] last_q;
	logic out_valid_q;

	logic signed [SB-1:0] ref_q [4];
	logic signed [SB-1:0] res_q;
	logic signed [SB-1:0] anti_q;
	logic signed [SB-1:0] res_out_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [DEN_W-1:0] den_q;

	logic mac_s1, mac_s2, nrm_s1, nrm_s2;
	logic signed [SB+CB-1:0] mprod_s2;
	logic [mrnlms_pkg::PROD_BITS-1:0] sq_s2;

	logic signed [2*SB-1:0] uprod_q;
	logic signed [CB-1:0] coef_hold_q;
	logic neg_q;
	logic [mrnlms_pkg::SCALED_BITS-1:0] scaled_q;

	logic [TW-1:0] pm1, p_inc, k_dec;
	logic [DW-1:0] rd;
	logic j_last, c_last, out_fire;

	logic dly_we, tap_we, lag_we, coef_we;
	logic [AD-1:0] dly_waddr, dly_raddr;
	logic [AT-1:0] tap_waddr, tap_raddr, lag_waddr, lag_raddr, coef_waddr, coef_raddr;
	logic [SB-1:0] dly_wdata, dly_rdata, tap_wdata, tap_rdata, lag_wdata, lag_rdata;
	logic [CB-1:0] coef_wdata, coef_rdata;
	logic div_start;
	mrnlms_pkg::div_rsp_t div_rsp;

	logic signed [SB:0] diff;
	logic signed [SB-1:0] res_d;
	logic signed [ACC_W:0] rsum;
	logic signed [SB-1:0] anti_d;
	logic signed [2*SB-1:0] sq_full;
	logic signed [2*SB-1:0] uabs;
	logic [mrnlms_pkg::PROD_BITS+mrnlms_pkg::STEP_BITS-1:0] scaled_full;
	logic [QB:0] qfull;
	logic signed [QB+1:0] delta;
	logic signed [CB+1:0] csum;
	logic [CB-1:0] coef_new;
	logic [CLW:0] clr_ext;

	assign pm1 = (p_q == '0) ? T_LAST : p_q - 1'b1;
	assign p_inc = (p_q == T_LAST) ? '0 : p_q + 1'b1;
	assign k_dec = (k_q == '0) ? T_LAST : k_q - 1'b1;
	assign rd = (dp_q == D_LAST) ? '0 : dp_q + 1'b1;
	assign j_last = j_q == T_LAST;
	assign c_last = ch_q == C_LAST;
	assign out_fire = (state_q == mrnlms_pkg::ST_OUT) && (!out_valid_q || out_ready);
	assign clr_ext = {1'b0, clr_q};

	assign diff = (SB+1)'(error_mic) - (SB+1)'(last_q);
	assign res_d = SB'(mrnlms_pkg::sat_to(64'(diff), SB));
	assign rsum = (ACC_W+1)'(acc_q) + RND_HALF;
	assign anti_d = SB'(mrnlms_pkg::sat_to(64'(rsum >>> mrnlms_pkg::CFRAC), SB));
	assign sq_full = $signed(lag_rdata) * $signed(lag_rdata);
	assign uabs = uprod_q[2*SB-1] ? -uprod_q : uprod_q;
	assign scaled_full = uabs[mrnlms_pkg::PROD_BITS-1:0] * step_q;
	assign qfull = {1'b0, div_rsp.quo} + (QB+1)'(div_rsp.round_up);
	assign delta = neg_q ? -$signed({1'b0, qfull}) : $signed({1'b0, qfull});
	assign csum = (CB+2)'(coef_hold_q) + (CB+2)'(delta);
	assign coef_new = CB'(mrnlms_pkg::sat_to(64'(csum), CB));

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		div_start = 1'b0;
		dly_we = 1'b0;
		tap_we = 1'b0;
		lag_we = 1'b0;
		coef_we = 1'b0;
		dly_waddr = bd_q + AD'(dp_q);
		dly_wdata = ref_q[2'(ch_q)];
		dly_raddr = bd_q + AD'(rd);
		tap_waddr = bt_q + AT'(p_q);
		tap_wdata = dly_rdata;
		tap_raddr = bt_q + AT'(k_q);
		lag_waddr = bt_q + AT'(p_q);
		lag_wdata = tap_rdata;
		lag_raddr = bt_q + AT'(k_q);
		coef_waddr = bt_q + AT'(j_q);
		coef_wdata = coef_new;
		coef_raddr = bt_q + AT'(j_q);
		unique case (state_q)
			mrnlms_pkg::ST_CLEAR: begin
				dly_we = clr_ext < (CLW+1)'(DC);
				tap_we = clr_ext < (CLW+1)'(TC);
				lag_we = tap_we;
				coef_we = tap_we;
				dly_waddr = clr_q[AD-1:0];
				tap_waddr = clr_q[AT-1:0];
				lag_waddr = clr_q[AT-1:0];
				coef_waddr = clr_q[AT-1:0];
				dly_wdata = '0;
				tap_wdata = '0;
				lag_wdata = '0;
				coef_wdata = '0;
				if (clr_q == CLR_LAST) state_d = mrnlms_pkg::ST_IDLE;
			end
			mrnlms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = mrnlms_pkg::ST_SHIFT_RD;
			end
			mrnlms_pkg::ST_SHIFT_RD: begin
				tap_raddr = bt_q + AT'(pm1);
				state_d = mrnlms_pkg::ST_SHIFT_WR;
			end
			mrnlms_pkg::ST_SHIFT_WR: begin
				dly_we = 1'b1;
				tap_we = 1'b1;
				lag_we = 1'b1;
				state_d = c_last ? mrnlms_pkg::ST_MAC : mrnlms_pkg::ST_SHIFT_RD;
			end
			mrnlms_pkg::ST_MAC: begin
				if (j_last && c_last) state_d = mrnlms_pkg::ST_MAC_DRAIN;
			end
			mrnlms_pkg::ST_MAC_DRAIN: begin
				if (!mac_s1 && !mac_s2) state_d = mrnlms_pkg::ST_OUT;
			end
			mrnlms_pkg::ST_OUT: begin
				if (out_fire) state_d = phase_q ? mrnlms_pkg::ST_NORM : mrnlms_pkg::ST_IDLE;
			end
			mrnlms_pkg::ST_NORM: begin
				lag_raddr = bt_q + AT'(j_q);
				if (j_last) state_d = mrnlms_pkg::ST_NORM_DRAIN;
			end
			mrnlms_pkg::ST_NORM_DRAIN: begin
				if (!nrm_s1 && !nrm_s2) state_d = mrnlms_pkg::ST_UPD_RD;
			end
			mrnlms_pkg::ST_UPD_RD: state_d = mrnlms_pkg::ST_UPD_MUL;
			mrnlms_pkg::ST_UPD_MUL: state_d = mrnlms_pkg::ST_UPD_SCALE;
			mrnlms_pkg::ST_UPD_SCALE: state_d = mrnlms_pkg::ST_UPD_DIV;
			mrnlms_pkg::ST_UPD_DIV: begin
				div_start = 1'b1;
				state_d = mrnlms_pkg::ST_UPD_WAIT;
			end
			mrnlms_pkg::ST_UPD_WAIT: begin
				if (div_rsp.done) state_d = mrnlms_pkg::ST_UPD_WR;
			end
			mrnlms_pkg::ST_UPD_WR: begin
				coef_we = 1'b1;
				if (!j_last) state_d = mrnlms_pkg::ST_UPD_RD;
				else if (c_last) state_d = mrnlms_pkg::ST_IDLE;
				else state_d = mrnlms_pkg::ST_NORM;
			end
			default: state_d = mrnlms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrnlms_pkg::ST_CLEAR;
			clr_q <= '0;
			p_q <= '0;
			dp_q <= '0;
			ch_q <= '0;
			bt_q <= '0;
			bd_q <= '0;
			j_q <= '0;
			k_q <= '0;
			phase_q <= 1'b0;
			step_q <= mrnlms_pkg::STEP_RESET;
			last_q <= '0;
			out_valid_q <= 1'b0;
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
			nrm_s1 <= 1'b0;
			nrm_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step_size_wr_en) step_q <= step_size;
			mac_s1 <= state_q == mrnlms_pkg::ST_MAC;
			nrm_s1 <= state_q == mrnlms_pkg::ST_NORM;
			mac_s2 <= mac_s1;
			nrm_s2 <= nrm_s1;
			if (out_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				mrnlms_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				mrnlms_pkg::ST_SHIFT_WR: begin
					if (c_last) begin
						ch_q <= '0;
						bt_q <= '0;
						bd_q <= '0;
						j_q <= '0;
						k_q <= p_q;
					end else begin
						ch_q <= ch_q + 1'b1;
						bt_q <= bt_q + T_STEP;
						bd_q <= bd_q + D_STEP;
					end
				end
				mrnlms_pkg::ST_MAC: begin
					if (j_last) begin
						j_q <= '0;
						k_q <= p_q;
						ch_q <= c_last ? '0 : ch_q + 1'b1;
						bt_q <= c_last ? '0 : bt_q + T_STEP;
					end else begin
						j_q <= j_q + 1'b1;
						k_q <= k_dec;
					end
				end
				mrnlms_pkg::ST_OUT: begin
					if (out_fire) begin
						last_q <= anti_d;
						phase_q <= !phase_q;
						// Positions advance here when no update follows; else after the update, which still uses the old ones.
						if (!phase_q) begin
							p_q <= p_inc;
							dp_q <= rd;
						end
					end
				end
				mrnlms_pkg::ST_NORM: j_q <= j_last ? '0 : j_q + 1'b1;
				mrnlms_pkg::ST_NORM_DRAIN: begin
					j_q <= '0;
					k_q <= p_q;
				end
				mrnlms_pkg::ST_UPD_WR: begin
					if (j_last) begin
						j_q <= '0;
						k_q <= p_q;
						if (c_last) begin
							ch_q <= '0;
							bt_q <= '0;
							p_q <= p_inc;
							dp_q <= rd;
						end else begin
							ch_q <= ch_q + 1'b1;
							bt_q <= bt_q + T_STEP;
						end
					end else begin
						j_q <= j_q + 1'b1;
						k_q <= k_dec;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ref_q[0] <= ref_0;
			ref_q[1] <= ref_1;
			ref_q[2] <= ref_2;
			ref_q[3] <= ref_3;
			res_q <= res_d;
		end
		mprod_s2 <= $signed(tap_rdata) * $signed(coef_rdata);
		sq_s2 <= sq_full[mrnlms_pkg::PROD_BITS-1:0];
		if (state_q == mrnlms_pkg::ST_SHIFT_WR && c_last) acc_q <= '0;
		else if (mac_s2) acc_q <= acc_q + ACC_W'(mprod_s2);
		if (out_fire || (state_q == mrnlms_pkg::ST_UPD_WR && j_last)) den_q <= DEN_ONE;
		else if (nrm_s2) den_q <= den_q + DEN_W'(sq_s2);
		if (state_q == mrnlms_pkg::ST_UPD_MUL) begin
			uprod_q <= res_q * $signed(lag_rdata);
			coef_hold_q <= $signed(coef_rdata);
		end
		if (state_q == mrnlms_pkg::ST_UPD_SCALE) begin
			neg_q <= uprod_q[2*SB-1];
			scaled_q <= scaled_full[mrnlms_pkg::SCALED_BITS-1:0];
		end
		if (out_fire) begin
			anti_q <= anti_d;
			res_out_q <= res_q;
		end
	end

	mrnlms_ram #(.WIDTH(SB), .DEPTH(DC)) u_dly_ram (
		.clk(clk), .we(dly_we), .waddr(dly_waddr), .wdata(dly_wdata),
		.raddr(dly_raddr), .rdata(dly_rdata)
	);

	mrnlms_ram #(.WIDTH(SB), .DEPTH(TC)) u_tap_ram (
		.clk(clk), .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
		.raddr(tap_raddr), .rdata(tap_rdata)
	);

	mrnlms_ram #(.WIDTH(SB), .DEPTH(TC)) u_lag_ram (
		.clk(clk), .we(lag_we), .waddr(lag_waddr), .wdata(lag_wdata),
		.raddr(lag_raddr), .rdata(lag_rdata)
	);

	mrnlms_ram #(.WIDTH(CB), .DEPTH(TC)) u_coef_ram (
		.clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(coef_raddr), .rdata(coef_rdata)
	);

	mrnlms_div #(.DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({scaled_q, {mrnlms_pkg::NUM_SH{1'b0}}}), .den(den_q), .rsp(div_rsp)
	);

	assign out_valid = out_valid_q;
	assign anti_noise = anti_q;
	assign residual = res_out_q;

endmodule

@@ hdl/mrnlms_chk.sv @@
module mrnlms_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] anti_noise,
	input logic [15:0] residual
);

	logic [1:0] pend_q;

	// Transactions accepted on the input whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(anti_noise) && $stable(residual))
		else $error("result changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second input transaction taken while one is in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown without a pending input transaction");

	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pend_q == 2'd0 || pend_q == 2'd1)
		else $error("input ready with too many transactions pending");

endmodule

bind multi_reference_nlms_anc_filter_core mrnlms_chk u_mrnlms_chk (.*);

@@ test/multi_reference_nlms_anc_filter_core_tb.sv @@
`timescale 1ns / 1ps

module multi_reference_nlms_anc_filter_core_tb;

	localparam int NTAPS = 15;
	localparam int NCH = 4;
	localparam int NDLY = 8;
	localparam int SBITS = mrnlms_pkg::SAMPLE_BITS;
	localparam int STBITS = mrnlms_pkg::STEP_BITS;
	// Covers the longest adaptation pass that can still run after the last result.
	localparam int SETTLE_CYCLES = 3000;

	typedef struct packed {
		logic signed [NCH-1:0][SBITS-1:0] refs;
		logic signed [SBITS-1:0] mic;
	} sample_t;

	typedef struct packed {
		logic signed [SBITS-1:0] anti;
		logic signed [SBITS-1:0] res;
	} canceller_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic step_size_wr_en = 1'b0;
	logic [STBITS-1:0] step_size = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SBITS-1:0] ref_0 = '0;
	logic signed [SBITS-1:0] ref_1 = '0;
	logic signed [SBITS-1:0] ref_2 = '0;
	logic signed [SBITS-1:0] ref_3 = '0;
	logic signed [SBITS-1:0] error_mic = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SBITS-1:0] anti_noise;
	logic signed [SBITS-1:0] residual;

	multi_reference_nlms_anc_filter_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.step_size_wr_en(step_size_wr_en),
		.step_size(step_size),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ref_0(ref_0),
		.ref_1(ref_1),
		.ref_2(ref_2),
		.ref_3(ref_3),
		.error_mic(error_mic),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.anti_noise(anti_noise),
		.residual(residual)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sample_t pending_samples[$];
	canceller_out_t expected_outputs[$];
	int errors = 0;
	int samples_sent = 0;
	int outputs_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_hold_req = 0;
	int recv_hold_cnt = 0;
	logic in_taken = 1'b0;

	// Canceller state mirrored in the testbench.
	logic [STBITS-1:0] model_step = mrnlms_pkg::STEP_RESET;
	longint dly_line[NDLY][NCH];
	longint tap_line[NTAPS][NCH];
	longint lag_line[NTAPS][NCH];
	longint coef[NTAPS][NCH];
	int dly_pos = 0;
	int tap_pos = 0;
	longint prev_anti = 0;
	bit adapt_now = 0;

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	task automatic predict_canceller(input sample_t s);
		int p;
		int rd;
		longint acc;
		longint res;
		longint anti;
		longint prod;
		longint lag;
		longint unsigned den;
		longint unsigned mag;
		longint unsigned q;
		canceller_out_t o;
		p = tap_pos;
		rd = (dly_pos + 1) % NDLY;
		acc = 0;
		res = clip(longint'(s.mic) - prev_anti, SBITS);
		for (int c = 0; c < NCH; c++) begin
			lag_line[p][c] = tap_line[(p + NTAPS - 1) % NTAPS][c];
			tap_line[p][c] = dly_line[rd][c];
			dly_line[dly_pos][c] = longint'($signed(s.refs[c]));
			for (int j = 0; j < NTAPS; j++)
				acc += tap_line[(p + NTAPS - j) % NTAPS][c] * coef[j][c];
		end
		anti = clip((acc + (longint'(1) <<< (mrnlms_pkg::CFRAC - 1))) >>> mrnlms_pkg::CFRAC,
			SBITS);
		prev_anti = anti;
		tap_pos = (p + 1) % NTAPS;
		dly_pos = rd;
		if (adapt_now) begin
			for (int c = 0; c < NCH; c++) begin
				den = longint'(1) <<< mrnlms_pkg::NORM_ONE_SH;
				for (int j = 0; j < NTAPS; j++)
					den += longint'(lag_line[j][c] * lag_line[j][c]);
				for (int j = 0; j < NTAPS; j++) begin
					lag = lag_line[(p + NTAPS - j) % NTAPS][c];
					prod = res * lag;
					mag = (prod < 0) ? -prod : prod;
					mag = (mag * model_step) << mrnlms_pkg::NUM_SH;
					q = mag / den + (((mag % den) >= den - den / 2) ? 1 : 0);
					coef[j][c] = clip(coef[j][c] + ((prod < 0) ? -longint'(q) : longint'(q)),
						mrnlms_pkg::COEF_BITS);
				end
			end
		end
		adapt_now = !adapt_now;
		o.anti = anti[SBITS-1:0];
		o.res = res[SBITS-1:0];
		expected_outputs.push_back(o);
	endtask

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			predict_canceller({ref_3, ref_2, ref_1, ref_0, error_mic});
			samples_sent++;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_t s;
				s = pending_samples.pop_front();
				ref_0 <= s.refs[0];
				ref_1 <= s.refs[1];
				ref_2 <= s.refs[2];
				ref_3 <= s.refs[3];
				error_mic <= s.mic;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (recv_hold_req > 0) begin
			recv_hold_cnt = recv_hold_req;
			recv_hold_req = 0;
		end
		if (recv_hold_cnt > 0) begin
			recv_hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			canceller_out_t want;
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected output anti_noise=%0d residual=%0d",
					$time, anti_noise, residual);
				errors++;
			end else begin
				want = expected_outputs.pop_front();
				if (anti_noise !== want.anti) begin
					$display("%0t: anti_noise expected %0d actual %0d",
						$time, want.anti, anti_noise);
					errors++;
				end
				if (residual !== want.res) begin
					$display("%0t: residual expected %0d actual %0d",
						$time, want.res, residual);
					errors++;
				end
			end
			outputs_checked++;
		end
	end

	function automatic logic signed [SBITS-1:0] rand_level(input int kind);
		case (kind)
			0: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
			1: return 16'($urandom);
			default: return 16'($signed($urandom_range(8191)) - 4096);
		endcase
	endfunction

	task automatic queue_random(input int n);
		sample_t s;
		int kind;
		repeat (n) begin
			kind = $urandom_range(99);
			kind = (kind < 5) ? 0 : (kind < 35) ? 1 : 2;
			for (int c = 0; c < NCH; c++)
				s.refs[c] = rand_level(kind);
			s.mic = rand_level($urandom_range(2));
			pending_samples.push_back(s);
		end
	endtask

	task automatic queue_fixed(input logic signed [SBITS-1:0] r,
		input logic signed [SBITS-1:0] m);
		sample_t s;
		for (int c = 0; c < NCH; c++)
			s.refs[c] = r;
		s.mic = m;
		pending_samples.push_back(s);
	endtask

	// The block may still be adapting after its last result, so settle first.
	task automatic drain_all();
		while (pending_samples.size() > 0 || in_valid || expected_outputs.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [STBITS-1:0] v);
		@(negedge clk);
		step_size <= v;
		step_size_wr_en <= 1'b1;
		@(negedge clk);
		step_size_wr_en <= 1'b0;
		model_step = v;
	endtask

	initial begin
		logic [STBITS-1:0] steps[5];
		for (int i = 0; i < NDLY; i++)
			for (int c = 0; c < NCH; c++)
				dly_line[i][c] = 0;
		for (int i = 0; i < NTAPS; i++)
			for (int c = 0; c < NCH; c++) begin
				tap_line[i][c] = 0;
				lag_line[i][c] = 0;
				coef[i][c] = 0;
			end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full-scale references with a strong step drive the coefficients and
		// the anti-noise into saturation, which in turn saturates the residual.
		write_step(16'hffff);
		queue_fixed(16'sh7fff, 16'sh7fff);
		queue_fixed(16'sh8000, 16'sh8000);
		queue_fixed(16'sh0000, 16'sh0000);
		queue_fixed(16'sh5555, 16'shaaaa);
		queue_fixed(16'shaaaa, 16'sh5555);
		for (int i = 0; i < 12; i++)
			queue_fixed(16'sh7fff, (i % 2) ? 16'sh8000 : 16'sh7fff);
		for (int i = 0; i < 6; i++)
			queue_fixed((i % 2) ? 16'sh8000 : 16'sh7fff, 16'sh8000);
		drain_all();

		steps[0] = mrnlms_pkg::STEP_RESET;
		steps[1] = 16'h0000;
		steps[2] = 16'hffff;
		steps[3] = 16'($urandom);
		steps[4] = 16'h0001;
		for (int ph = 0; ph < 5; ph++) begin
			write_step(steps[ph]);
			if (ph < 2) begin
				send_idle_pct = 10;
				recv_idle_pct = 55;
			end else if (ph < 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 2) begin
				// Long output back-pressure while samples keep coming.
				send_idle_pct = 0;
				recv_hold_req = 6000;
				queue_random(143);
				while (pending_samples.size() > 0) @(posedge clk);
				send_idle_pct = 55;
				queue_random(143);
			end else if (ph == 3) begin
				queue_random(143);
				while (pending_samples.size() > 0 || in_valid || expected_outputs.size() > 0)
					@(posedge clk);
				queue_random(143);
			end else begin
				queue_random(286);
			end
			drain_all();
		end

		$display("Sent %0d samples and checked %0d outputs across five step sizes,",
			samples_sent, outputs_checked);
		$display("with input and output stalls, long back-pressure and a full drain.");
		if (errors == 0 && expected_outputs.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d outputs missing", errors, expected_outputs.size());
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#(64'd2000 * 64'd1000 * 64'd400);
		$display("timeout with %0d outputs outstanding", expected_outputs.size());
		$display("tb: failure");
		$finish;
	end

endmodule
